// ===== hdl/magma_block_cipher_macros.svh =====
// assertion macros used by the checker file
`ifndef MAGMA_BLOCK_CIPHER_MACROS_SVH
`define MAGMA_BLOCK_CIPHER_MACROS_SVH

// checked only while out of reset
`define MAGMA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MAGMA_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/magma_pkg.sv =====
`timescale 1ns / 1ps

package magma_pkg;

    localparam int unsigned HALF_W    = 32;
    localparam int unsigned BLOCK_W   = 64;
    localparam int unsigned KEY_WORDS = 8;
    localparam int unsigned KEY_IDX_W = 3;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned ROUNDS    = 32;
    localparam int unsigned ROUND_W   = 5;
    localparam int unsigned ROT_LEFT  = 11;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

    typedef logic [HALF_W-1:0] t_half;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    localparam logic [3:0] SBOX [0:7][0:15] = '{
        '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
          4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2},
        '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
          4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
        '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
          4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
        '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
          4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
        '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
          4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
        '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
          4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
        '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
          4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
        '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
          4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1}
    };

    // key slot for a round; decryption walks the schedule backwards
    function automatic logic [KEY_IDX_W-1:0] key_index(
        input logic [ROUND_W-1:0] round,
        input logic               encrypt
    );
        logic forward;
        if (encrypt) begin
            forward = (round[4:3] != 2'b11);
        end else begin
            forward = (round[4:3] == 2'b00);
        end
        return forward ? round[2:0] : ~round[2:0];
    endfunction

endpackage

// ===== hdl/magma_round.sv =====
`timescale 1ns / 1ps

module magma_round (
    input  magma_pkg::t_half i_left,
    input  magma_pkg::t_half i_right,
    input  magma_pkg::t_half i_key,
    output magma_pkg::t_half o_new_right
);

    magma_pkg::t_half w_sum;
    magma_pkg::t_half w_sub;

    assign w_sum = i_right + i_key;

    // first table on the top nibble
    always_comb begin
        for (int n = 0; n < 8; n++) begin
            w_sub[28-4*n +: 4] = magma_pkg::SBOX[n][w_sum[28-4*n +: 4]];
        end
    end

    assign o_new_right = i_left ^ {w_sub[magma_pkg::HALF_W-magma_pkg::ROT_LEFT-1:0],
                                   w_sub[magma_pkg::HALF_W-1:magma_pkg::HALF_W-magma_pkg::ROT_LEFT]};

endmodule

// ===== hdl/magma_block_cipher.sv =====
`timescale 1ns / 1ps

// Magma (GOST R 34.12-2015) 64-bit block cipher core with a 256-bit key held in eight
// 32-bit key registers (index 0 is key bits 255..224); i_encrypt high encrypts, low
// decrypts. One shared round unit runs once per cycle while a block is in the loop;
// a new block is taken only once the last one has left it. The last round writes the
// output register directly, and the input side is ready again in the same cycle that
// the result becomes valid. It stays ready while a finished result waits in the
// output register; only if a second result finishes before the first is taken does
// the last round hold. Key writes go in through the configuration channel; the user
// must keep them between blocks (not enforced); indices above 7 are ignored.
module magma_block_cipher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [magma_pkg::BLOCK_W-1:0]       i_block_in,
    input  logic                                i_encrypt,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [magma_pkg::BLOCK_W-1:0]       o_block_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [magma_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [magma_pkg::HALF_W-1:0]        i_cfg_data
);

    magma_pkg::t_state               r_state, n_state;
    logic [magma_pkg::ROUND_W-1:0]   r_round;
    logic                            r_encrypt;
    magma_pkg::t_half                r_left, r_right;
    magma_pkg::t_half                r_key [magma_pkg::KEY_WORDS];
    logic                            r_out_valid;
    logic [magma_pkg::BLOCK_W-1:0]   r_block_out;

    magma_pkg::t_half                w_sched_key;
    magma_pkg::t_half                w_new_right;
    logic                            w_in_acc;
    logic                            w_out_acc;
    logic                            w_last;
    logic                            w_finish;

    assign o_in_ready  = (r_state == magma_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_block_out = r_block_out;
    assign o_cfg_ready = 1'b1;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = r_out_valid && i_out_ready;
    assign w_last    = (r_state == magma_pkg::ST_RUN) && (r_round == magma_pkg::LAST_ROUND);
    assign w_finish  = w_last && (!r_out_valid || i_out_ready);

    assign w_sched_key = r_key[magma_pkg::key_index(r_round, r_encrypt)];

    magma_round u_round (
        .i_left      (r_left),
        .i_right     (r_right),
        .i_key       (w_sched_key),
        .o_new_right (w_new_right)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            magma_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = magma_pkg::ST_RUN;
                end
            end
            magma_pkg::ST_RUN: begin
                if (w_finish) begin
                    n_state = magma_pkg::ST_IDLE;
                end
            end
            default: n_state = magma_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= magma_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_round     <= '0;
        end else begin
            r_state <= n_state;
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc) begin
                r_round <= '0;
            end else if ((r_state == magma_pkg::ST_RUN) && !w_last) begin
                r_round <= r_round + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_left    <= i_block_in[magma_pkg::BLOCK_W-1:magma_pkg::HALF_W];
            r_right   <= i_block_in[magma_pkg::HALF_W-1:0];
            r_encrypt <= i_encrypt;
        end else if ((r_state == magma_pkg::ST_RUN) && !w_last) begin
            r_left  <= r_right;
            r_right <= w_new_right;
        end
        // last round skips the swap
        if (w_finish) begin
            r_block_out <= {w_new_right, r_right};
        end
    end

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < magma_pkg::KEY_WORDS; k++) begin
                r_key[k] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready
                     && (i_cfg_index < magma_pkg::CFG_IDX_W'(magma_pkg::KEY_WORDS))) begin
            r_key[i_cfg_index[magma_pkg::KEY_IDX_W-1:0]] <= i_cfg_data;
        end
    end

endmodule

// ===== hdl/magma_checker.sv =====
`timescale 1ns / 1ps
`include "magma_block_cipher_macros.svh"

module magma_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [magma_pkg::BLOCK_W-1:0]       o_block_out
);

    // no result pending after reset
    `MAGMA_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // an accepted transaction occupies the round unit
    `MAGMA_ASSERT(a_busy_after_accept, (i_in_valid && o_in_ready) |=> !o_in_ready, "input ready right after a transaction")

    // a new result only comes out of the round loop
    `MAGMA_ASSERT(a_result_from_run, $rose(o_out_valid) |-> $past(!o_in_ready), "result without a block in the loop")

    // stalled result holds
    `MAGMA_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_block_out)), "stalled result changed")

endmodule

bind magma_block_cipher magma_checker u_magma_checker (.*);

// ===== verif/magma_block_cipher_test.sv =====
`timescale 1ns / 1ps

module magma_block_cipher_test;

    typedef logic [magma_pkg::BLOCK_W-1:0] t_block;

    typedef struct {
        t_block blk;
        logic   enc;
    } t_cipher_item;

    localparam int unsigned CIPHER_ROUNDS  = 32;
    localparam int unsigned RANDOM_PHASES  = 6;
    localparam int unsigned PHASE_ITEMS    = 200;
    localparam int unsigned DRAIN_CYCLES   = 40;
    localparam int unsigned HOLD_AT        = 250;
    localparam int unsigned HOLD_CYCLES    = 700;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    localparam bit [3:0] SUBST [0:7][0:15] = '{
        '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
          4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2},
        '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
          4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
        '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
          4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
        '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
          4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
        '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
          4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
        '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
          4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
        '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
          4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
        '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
          4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [magma_pkg::BLOCK_W-1:0]   i_block_in;
    logic                            i_encrypt;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [magma_pkg::BLOCK_W-1:0]   o_block_out;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [magma_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [magma_pkg::HALF_W-1:0]    i_cfg_data;

    magma_pkg::t_half key_model [magma_pkg::KEY_WORDS];
    t_cipher_item     pending_items [$];
    t_block           expected_blocks [$];
    t_cipher_item     next_item;
    t_block           want_block;
    int               items_pushed = 0;
    int               failures = 0;
    int               in_gap = 0;
    int               out_wait = 0;
    int               rx_count = 0;
    int               quiet_cycles = 0;
    bit               no_idle = 1'b0;

    magma_block_cipher uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_block_in  (i_block_in),
        .i_encrypt   (i_encrypt),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_block_out (o_block_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic magma_pkg::t_half feistel_mix(magma_pkg::t_half half,
                                                     magma_pkg::t_half subkey);
        magma_pkg::t_half sum;
        magma_pkg::t_half sub;
        sum = half + subkey;
        sub = '0;
        for (int n = 0; n < 8; n++) begin
            sub[28-4*n +: 4] = SUBST[n][sum[28-4*n +: 4]];
        end
        return {sub[20:0], sub[31:21]};
    endfunction

    // encryption walks K1..K8 three times then K8..K1, decryption the reverse
    function automatic int unsigned sched_slot(int unsigned r, logic enc);
        int unsigned step;
        step = enc ? r : CIPHER_ROUNDS - 1 - r;
        return (step < 24) ? (step % 8) : (7 - step % 8);
    endfunction

    function automatic t_block predict_block(t_block blk, logic enc);
        magma_pkg::t_half left;
        magma_pkg::t_half right;
        magma_pkg::t_half mixed;
        left  = blk[63:32];
        right = blk[31:0];
        for (int unsigned r = 0; r < CIPHER_ROUNDS; r++) begin
            mixed = left ^ feistel_mix(right, key_model[sched_slot(r, enc)]);
            left  = right;
            right = mixed;
        end
        return {right, left};
    endfunction

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic t_block rand_block();
        t_block blk;
        case ($urandom_range(0, 7))
            0: blk = t_block'(1) << $urandom_range(0, magma_pkg::BLOCK_W - 1);
            1: blk = ~(t_block'(1) << $urandom_range(0, magma_pkg::BLOCK_W - 1));
            2: blk = $urandom_range(0, 1) ? '1 : '0;
            default: blk = {$urandom, $urandom};
        endcase
        return blk;
    endfunction

    function automatic magma_pkg::t_half rand_key_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_block(input t_block blk, input logic enc);
        t_cipher_item item;
        item.blk = blk;
        item.enc = enc;
        pending_items.push_back(item);
        items_pushed++;
    endtask

    // valid stays high across back-to-back writes; the caller lowers it
    task automatic cfg_write(input logic [magma_pkg::CFG_IDX_W-1:0] idx,
                             input magma_pkg::t_half data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < magma_pkg::KEY_WORDS) begin
            key_model[idx[magma_pkg::KEY_IDX_W-1:0]] = data;
        end
    endtask

    task automatic program_keys(input magma_pkg::t_half words [magma_pkg::KEY_WORDS],
                                input bit [magma_pkg::KEY_WORDS-1:0] sel,
                                input logic [magma_pkg::CFG_IDX_W-1:0] stray_idx,
                                input magma_pkg::t_half stray_data);
        for (int k = 0; k < magma_pkg::KEY_WORDS; k++) begin
            if (sel[k]) begin
                cfg_write(magma_pkg::CFG_IDX_W'(k), words[k]);
            end
        end
        // out of range index, must leave the key untouched
        cfg_write(stray_idx, stray_data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (rx_count != items_pushed) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_block_in <= '0;
            i_encrypt  <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_blocks.push_back(predict_block(i_block_in, i_encrypt));
                in_gap = draw_gap();
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    next_item = pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    i_block_in <= next_item.blk;
                    i_encrypt  <= next_item.enc;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_wait = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_blocks.size() == 0) begin
                    $error("unexpected transaction: block_out %h", o_block_out);
                    failures++;
                end else begin
                    want_block = expected_blocks.pop_front();
                    if (o_block_out !== want_block) begin
                        $error("block_out mismatch: expected %h, actual %h",
                               want_block, o_block_out);
                        failures++;
                    end
                end
                rx_count++;
                // long hold-off so the core fills up and stalls its input
                out_wait = (rx_count == HOLD_AT) ? HOLD_CYCLES : draw_gap();
            end else if (out_wait > 0) begin
                out_wait--;
            end
            i_out_ready <= (out_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                     (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        magma_pkg::t_half words [magma_pkg::KEY_WORDS];
        magma_pkg::t_half ref_key [magma_pkg::KEY_WORDS];
        bit [magma_pkg::KEY_WORDS-1:0] sel;

        ref_key = '{32'hffeeddcc, 32'hbbaa9988, 32'h77665544, 32'h33221100,
                    32'hf0f1f2f3, 32'hf4f5f6f7, 32'hf8f9fafb, 32'hfcfdfeff};
        for (int k = 0; k < magma_pkg::KEY_WORDS; k++) begin
            key_model[k] = '0;
        end
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // all-zero key straight out of reset
        push_block('0, 1'b1);
        push_block('0, 1'b0);
        push_block('1, 1'b1);
        push_block('1, 1'b0);
        push_block(64'h8000000000000001, 1'b1);
        push_block(64'h0000000000000001, 1'b0);
        drain();

        // standard key with stray writes to both ends of the unused range
        cfg_write(magma_pkg::CFG_IDX_W'(8), '1);
        program_keys(ref_key, '1, magma_pkg::CFG_IDX_W'(15), '1);
        push_block(64'hfedcba9876543210, 1'b1);
        push_block(64'h4ee901e5c2d8ca3d, 1'b0);
        push_block('0, 1'b1);
        push_block('1, 1'b0);
        push_block(64'h00000000ffffffff, 1'b1);
        push_block(64'hffffffff00000000, 1'b1);
        push_block(64'h00000000ffffffff, 1'b0);
        push_block(64'hffffffff00000000, 1'b0);
        push_block(64'haaaaaaaaaaaaaaaa, 1'b1);
        push_block(64'h5555555555555555, 1'b0);
        push_block(64'h8000000000000000, 1'b1);
        push_block(64'h7fffffffffffffff, 1'b0);
        push_block(64'h0123456789abcdef, 1'b1);
        push_block(64'h0123456789abcdef, 1'b0);
        drain();

        // all-ones key
        for (int k = 0; k < magma_pkg::KEY_WORDS; k++) begin
            words[k] = '1;
        end
        program_keys(words, '1, magma_pkg::CFG_IDX_W'(9), '0);
        push_block('0, 1'b1);
        push_block('0, 1'b0);
        push_block('1, 1'b1);
        push_block('1, 1'b0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            for (int k = 0; k < magma_pkg::KEY_WORDS; k++) begin
                words[k] = rand_key_word();
            end
            sel = (p == 0) ? '1 : magma_pkg::KEY_WORDS'($urandom);
            program_keys(words, sel, magma_pkg::CFG_IDX_W'($urandom_range(8, 15)), $urandom);
            no_idle = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                push_block(rand_block(), 1'($urandom));
            end
            drain();
        end

        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
